>>> hdl/plgt_pkg.sv
// Shared types, codes and helpers for the peer liveness gossip table.
package plgt_pkg;

  localparam int PEERS  = 16;
  localparam int IDX_W  = 4;
  localparam int SIZE_W = 5;
  localparam int AGE_W  = 33;

  localparam logic [AGE_W-1:0] AGE_UNKNOWN = {AGE_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_ENTRY  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_RANGE  = 2'd1,
    ERR_SELF   = 2'd2,
    ERR_GOSSIP = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    CFG_TEAM_SIZE  = 3'd0,
    CFG_SELF_INDEX = 3'd1,
    CFG_DIRECT_TTL = 3'd2,
    CFG_GOSSIP_AGE = 3'd3,
    CFG_CLOSURE    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ms;
  } stamp_t;

  // One table row; an unwritten row reads as all zero (every stamp invalid).
  typedef struct packed {
    stamp_t      known;
    stamp_t      direct;
    stamp_t      pos;
    stamp_t      rep_time;
    logic [15:0] rep_mask;
  } entry_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    entry_t             data;
  } wr_req_t;

  function automatic logic [AGE_W-1:0] age_of(input stamp_t s, input logic [31:0] now);
    logic [AGE_W-1:0] r;
    if (!s.valid) r = AGE_UNKNOWN;
    else if (now < s.ms) r = '0;
    else r = {1'b0, now - s.ms};
    return r;
  endfunction

endpackage

>>> hdl/peer_liveness_gossip_table_unit.sv
// Top level of the peer liveness gossip table.
// Header, gossip entry and query transactions pass through S_PREP and S_PREP2 (gossip age
// arithmetic), S_EXEC (table update or query) and S_DONE, which loads the output register.
// A tick walks the table memory one row per cycle in S_TICK, with reads pipelined one row
// ahead of the update; the relay closure mask is gathered in that same walk and applied in
// S_CLOSE, which is skipped with closure disabled. While the table is unconfigured every
// transaction goes straight from S_IDLE to S_DONE. s_tready rises again in the cycle after
// the result is registered, and a result still held by m_tready stalls the next result in
// its last cycle. A team_size or self_index write clears the table at once through per-row
// valid bits.
module peer_liveness_gossip_table_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [3:0] peer_index, [35:4] time_ms, [36] time_valid, [68:37] sender_time_ms,
  // [69] sender_time_valid, [85:70] range_mask, [86] finished_flag,
  // [89:87] mode_level, [90] has_position
  input  logic [95:0]  s_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] error_code, [2] peer_in_comms, [35:3] last_known_age_ms,
  // [68:36] position_age_ms, [101:69] last_direct_age_ms, [117:102] in_comms_mask,
  // [133:118] receiving_mask, [137:134] lost_count
  output logic [143:0] m_tdata
);

  localparam int P  = plgt_pkg::PEERS;
  localparam int IW = plgt_pkg::IDX_W;
  localparam int AW = plgt_pkg::AGE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_PREP2, S_EXEC, S_TICK, S_CLOSE, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [plgt_pkg::SIZE_W-1:0] team_size;
  logic [IW-1:0]               self_index;
  logic [31:0]                 direct_ttl;
  logic [31:0]                 gossip_max_age;
  logic                        closure_en;

  // latch from the last header
  logic [31:0]      lat_receipt;
  plgt_pkg::stamp_t lat_sender_time;
  logic [IW-1:0]    lat_sender;

  // status vectors
  logic [P-1:0] direct_v, oneway_v, comms_v, reach;

  // current transaction
  plgt_pkg::cmd_t cmd_q;
  logic [IW-1:0]  idx_q;
  logic [31:0]    time_q, stime_q;
  logic           tv_q, stv_q, hp_q;
  logic [15:0]    rmask_q;
  logic           ok1, ok2;
  logic [31:0]    age_q, at_q;

  logic [plgt_pkg::SIZE_W-1:0] cnt;
  logic                        p_v;
  logic [IW-1:0]               p_i;

  plgt_pkg::err_t   res_err;
  logic             res_pic;
  logic [AW-1:0]    res_ak, res_ap, res_ad;

  plgt_pkg::entry_t  rd_data;
  plgt_pkg::wr_req_t wr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              clear;

  logic                        configured;
  logic [plgt_pkg::SIZE_W-1:0] n;
  logic                        accept;

  assign configured = (team_size != '0) && (team_size <= plgt_pkg::SIZE_W'(P))
                      && ({1'b0, self_index} < team_size);
  assign n        = configured ? team_size : '0;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign clear    = cfg_we && (cfg_index == plgt_pkg::CFG_TEAM_SIZE
                               || cfg_index == plgt_pkg::CFG_SELF_INDEX);

  plgt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // tick row evaluation
  logic tk_recv, tk_mutual, tk_active;
  logic [31:0] tk_diff;
  always_comb begin
    tk_diff   = time_q - rd_data.rep_time.ms;
    tk_recv   = rd_data.rep_time.valid && (time_q < rd_data.rep_time.ms || tk_diff <= direct_ttl);
    tk_mutual = tk_recv && rd_data.rep_mask[self_index];
    tk_active = (state == S_TICK) && p_v && (p_i != self_index);
  end

  logic idx_in;
  assign idx_in = {1'b0, idx_q} < n;

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = s_tdata[3:0];
    wr      = '0;
    wr.data = rd_data;
    if (accept) begin
      rd_en = 1'b1;
    end else if (state == S_TICK && cnt < n) begin
      rd_en   = 1'b1;
      rd_addr = cnt[IW-1:0];
    end
    if (tk_active && tk_mutual) begin
      wr.en          = 1'b1;
      wr.addr        = p_i;
      wr.data.direct = rd_data.rep_time;
      if (!rd_data.known.valid || rd_data.rep_time.ms > rd_data.known.ms) begin
        wr.data.known = rd_data.rep_time;
      end
    end else if (state == S_EXEC && configured && idx_in) begin
      wr.addr = idx_q;
      case (cmd_q)
        plgt_pkg::CMD_HEADER: begin
          if (idx_q != self_index) begin
            wr.en            = 1'b1;
            wr.data.known    = '{valid: 1'b1, ms: time_q};
            wr.data.rep_time = '{valid: 1'b1, ms: time_q};
            wr.data.rep_mask = rmask_q;
            if (hp_q) wr.data.pos = '{valid: 1'b1, ms: time_q};
          end
        end
        plgt_pkg::CMD_ENTRY: begin
          if (idx_q != self_index && idx_q != lat_sender && ok2
              && (!rd_data.known.valid || at_q > rd_data.known.ms)) begin
            wr.en         = 1'b1;
            wr.data.known = '{valid: 1'b1, ms: at_q};
            if (hp_q) wr.data.pos = '{valid: 1'b1, ms: at_q};
          end
        end
        default: ;
      endcase
    end
  end

  // output masks from the status vectors
  logic [P-1:0] cm, rm;
  logic [4:0]   lost;
  always_comb begin
    cm   = '0;
    rm   = '0;
    lost = '0;
    if (n != '0) begin
      rm[self_index] = 1'b1;
      for (int i = 0; i < P; i++) begin
        if (plgt_pkg::SIZE_W'(i) < n) begin
          cm[i] = comms_v[i];
          if (IW'(i) != self_index) begin
            if (direct_v[i] || oneway_v[i]) rm[i] = 1'b1;
            if (!comms_v[i]) lost = lost + 5'd1;
          end
        end
      end
    end
  end

  logic [P-1:0] self_bit, cfg_self_bit;
  assign self_bit     = P'(1) << self_index;
  assign cfg_self_bit = (cfg_index == plgt_pkg::CFG_SELF_INDEX)
                        ? P'(1) << cfg_wdata[IW-1:0] : self_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      team_size       <= plgt_pkg::SIZE_W'(1);
      self_index      <= '0;
      direct_ttl      <= 32'd1000;
      gossip_max_age  <= 32'd1000;
      closure_en      <= 1'b1;
      lat_receipt     <= '0;
      lat_sender_time <= '0;
      lat_sender      <= '0;
      direct_v        <= P'(1);
      comms_v         <= P'(1);
      oneway_v        <= '0;
      cnt             <= '0;
      p_v             <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          plgt_pkg::CFG_TEAM_SIZE:  team_size      <= cfg_wdata[plgt_pkg::SIZE_W-1:0];
          plgt_pkg::CFG_SELF_INDEX: self_index     <= cfg_wdata[IW-1:0];
          plgt_pkg::CFG_DIRECT_TTL: direct_ttl     <= cfg_wdata;
          plgt_pkg::CFG_GOSSIP_AGE: gossip_max_age <= cfg_wdata;
          plgt_pkg::CFG_CLOSURE:    closure_en     <= cfg_wdata[0];
          default: ;
        endcase
        if (clear) begin
          direct_v        <= cfg_self_bit;
          comms_v         <= cfg_self_bit;
          oneway_v        <= '0;
          lat_receipt     <= '0;
          lat_sender_time <= '0;
          lat_sender      <= '0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= plgt_pkg::cmd_t'(s_tuser);
            idx_q   <= s_tdata[3:0];
            time_q  <= s_tdata[35:4];
            tv_q    <= s_tdata[36];
            stime_q <= s_tdata[68:37];
            stv_q   <= s_tdata[69];
            rmask_q <= s_tdata[85:70];
            hp_q    <= s_tdata[90];
            res_pic <= 1'b0;
            cnt     <= '0;
            p_v     <= 1'b0;
            reach   <= '0;
            if (!configured) begin
              res_err <= plgt_pkg::ERR_RANGE;
              res_ak  <= plgt_pkg::AGE_UNKNOWN;
              res_ap  <= plgt_pkg::AGE_UNKNOWN;
              res_ad  <= plgt_pkg::AGE_UNKNOWN;
              state   <= S_DONE;
            end else begin
              res_err <= plgt_pkg::ERR_OK;
              res_ak  <= '0;
              res_ap  <= '0;
              res_ad  <= '0;
              if (plgt_pkg::cmd_t'(s_tuser) == plgt_pkg::CMD_TICK) begin
                state <= S_TICK;
              end else begin
                state <= S_PREP;
              end
            end
          end
        end
        S_PREP: begin
          ok1   <= tv_q && lat_sender_time.valid && time_q <= lat_sender_time.ms;
          age_q <= lat_sender_time.ms - time_q;
          state <= S_PREP2;
        end
        S_PREP2: begin
          ok2   <= ok1 && age_q <= gossip_max_age && age_q <= lat_receipt;
          at_q  <= lat_receipt - age_q;
          state <= S_EXEC;
        end
        S_EXEC: begin
          case (cmd_q)
            plgt_pkg::CMD_HEADER: begin
              if (!idx_in) begin
                res_err <= plgt_pkg::ERR_RANGE;
              end else if (idx_q == self_index) begin
                res_err <= plgt_pkg::ERR_SELF;
              end else begin
                lat_receipt     <= time_q;
                lat_sender      <= idx_q;
                lat_sender_time <= '{valid: stv_q, ms: stv_q ? stime_q : 32'd0};
              end
            end
            plgt_pkg::CMD_ENTRY: begin
              if (!idx_in) res_err <= plgt_pkg::ERR_GOSSIP;
            end
            default: begin
              if (!idx_in) begin
                res_err <= plgt_pkg::ERR_RANGE;
                res_ak  <= plgt_pkg::AGE_UNKNOWN;
                res_ap  <= plgt_pkg::AGE_UNKNOWN;
                res_ad  <= plgt_pkg::AGE_UNKNOWN;
              end else begin
                res_pic <= comms_v[idx_q];
                res_ap  <= plgt_pkg::age_of(rd_data.pos, time_q);
                if (idx_q == self_index) begin
                  res_ak <= '0;
                  res_ad <= '0;
                end else begin
                  res_ak <= plgt_pkg::age_of(rd_data.known, time_q);
                  res_ad <= plgt_pkg::age_of(rd_data.direct, time_q);
                end
              end
            end
          endcase
          state <= S_DONE;
        end
        S_TICK: begin
          if (cnt < n) cnt <= cnt + plgt_pkg::SIZE_W'(1);
          p_v <= cnt < n;
          p_i <= cnt[IW-1:0];
          if (tk_active) begin
            direct_v[p_i] <= tk_mutual;
            comms_v[p_i]  <= tk_mutual;
            oneway_v[p_i] <= tk_recv && !tk_mutual;
            if (tk_mutual) reach <= reach | rd_data.rep_mask;
          end
          if (!p_v && cnt >= n) state <= closure_en ? S_CLOSE : S_DONE;
        end
        S_CLOSE: begin
          for (int i = 0; i < P; i++) begin
            if (plgt_pkg::SIZE_W'(i) < n && IW'(i) != self_index && !direct_v[i] && reach[i])
              comms_v[i] <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, lost[3:0], rm, cm, res_ad, res_ap, res_ak, res_pic, res_err};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/plgt_table.sv
// Per-peer table memory with registered read and per-row valid bits.
module plgt_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      rd_en,
  input  logic [plgt_pkg::IDX_W-1:0] rd_addr,
  output plgt_pkg::entry_t          rd_data,
  input  plgt_pkg::wr_req_t         wr
);

  plgt_pkg::entry_t          mem [plgt_pkg::PEERS];
  logic [plgt_pkg::PEERS-1:0] row_valid;
  plgt_pkg::entry_t          rd_q;
  logic                      rd_ok;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= row_valid[rd_addr] && !(rst || clear);
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

>>> verif/peer_liveness_gossip_table_checker.sv
// Checker for the peer liveness gossip table: shadow table, predictor and compare.
module peer_liveness_gossip_table_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,
  output int           fails
);

  localparam logic [7:0] F_KNOWN = 8'h01, F_DIRECT = 8'h02, F_ONEWAY = 8'h04,
                         F_COMMS = 8'h08, F_FIN = 8'h10, F_POS = 8'h20, F_RELAY = 8'h40;

  typedef struct {
    plgt_pkg::err_t err;
    logic        pic;
    logic [32:0] known_age;
    logic [32:0] pos_age;
    logic [32:0] direct_age;
    logic [15:0] comms_mask;
    logic [15:0] recv_mask;
    logic [3:0]  lost;
  } status_t;

  logic [4:0]  team_sz;
  logic [3:0]  self_id;
  logic [31:0] ttl_ms, gossip_age_ms;
  logic        closure_on;

  logic [7:0]       flags    [plgt_pkg::PEERS];
  logic [2:0]       mode_lvl [plgt_pkg::PEERS];
  plgt_pkg::stamp_t heard_at [plgt_pkg::PEERS];
  plgt_pkg::stamp_t direct_at[plgt_pkg::PEERS];
  plgt_pkg::stamp_t pos_at   [plgt_pkg::PEERS];
  plgt_pkg::stamp_t rep_at   [plgt_pkg::PEERS];
  logic [15:0]      rep_mask [plgt_pkg::PEERS];
  logic [31:0]      hdr_rx_ms;
  plgt_pkg::stamp_t hdr_tx;
  logic [3:0]       hdr_peer;

  status_t expected_status[$];

  function automatic void wipe_table();
    for (int i = 0; i < plgt_pkg::PEERS; i++) begin
      flags[i] = '0; mode_lvl[i] = '0; heard_at[i] = '0; direct_at[i] = '0;
      pos_at[i] = '0; rep_at[i] = '0; rep_mask[i] = '0;
    end
    hdr_rx_ms = '0; hdr_tx = '0; hdr_peer = '0;
    flags[self_id] = F_KNOWN | F_DIRECT | F_COMMS;
  endfunction

  function automatic logic [32:0] stamp_age(plgt_pkg::stamp_t s, logic [31:0] now);
    if (!s.valid) return plgt_pkg::AGE_UNKNOWN;
    if (now < s.ms) return '0;
    return {1'b0, now - s.ms};
  endfunction

  function automatic status_t predict_status(plgt_pkg::cmd_t c, logic [95:0] d);
    status_t     r;
    logic [3:0]  idx;
    logic [31:0] now, tx_age, at_ms;
    logic [2:0]  m;
    int          n;
    logic        recv, mutual;
    idx = d[3:0]; now = d[35:4]; m = d[89:87];
    n = (team_sz < 5'd1 || team_sz > 5'(plgt_pkg::PEERS) || {1'b0, self_id} >= team_sz)
        ? 0 : int'(team_sz);
    r.err = plgt_pkg::ERR_OK; r.pic = 1'b0;
    r.known_age = '0; r.pos_age = '0; r.direct_age = '0;
    r.comms_mask = '0; r.recv_mask = '0; r.lost = '0;
    if (n == 0) begin
      r.err = plgt_pkg::ERR_RANGE;
      r.known_age = plgt_pkg::AGE_UNKNOWN; r.pos_age = plgt_pkg::AGE_UNKNOWN;
      r.direct_age = plgt_pkg::AGE_UNKNOWN;
      return r;
    end
    case (c)
      plgt_pkg::CMD_HEADER: begin
        if (idx >= n) r.err = plgt_pkg::ERR_RANGE;
        else if (idx == self_id) r.err = plgt_pkg::ERR_SELF;
        else begin
          flags[idx] |= F_KNOWN;
          if (d[86]) flags[idx] |= F_FIN; else flags[idx] &= ~F_FIN;
          mode_lvl[idx] = m;
          heard_at[idx] = '{1'b1, now};
          if (d[90]) begin
            flags[idx] |= F_POS;
            pos_at[idx] = '{1'b1, now};
          end
          rep_mask[idx] = d[85:70];
          rep_at[idx] = '{1'b1, now};
          hdr_rx_ms = now; hdr_peer = idx;
          if (d[69]) hdr_tx = '{1'b1, d[68:37]};
          else hdr_tx = '0;
        end
      end
      plgt_pkg::CMD_ENTRY: begin
        if (idx >= n) r.err = plgt_pkg::ERR_GOSSIP;
        else if (idx != self_id && idx != hdr_peer) begin
          if (d[36] && hdr_tx.valid && now <= hdr_tx.ms) begin
            tx_age = hdr_tx.ms - now;
            if (tx_age <= gossip_age_ms && tx_age <= hdr_rx_ms) begin
              at_ms = hdr_rx_ms - tx_age;
              flags[idx] |= F_KNOWN;
              if (!heard_at[idx].valid || at_ms > heard_at[idx].ms) begin
                heard_at[idx] = '{1'b1, at_ms};
                if (d[90]) begin
                  flags[idx] |= F_POS;
                  pos_at[idx] = '{1'b1, at_ms};
                end
              end
            end
          end
          if (d[86]) flags[idx] |= F_KNOWN | F_FIN;
          if (m != 3'd0) begin
            flags[idx] |= F_KNOWN;
            if (m > mode_lvl[idx]) mode_lvl[idx] = m;
          end
        end
      end
      plgt_pkg::CMD_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (i == self_id) continue;
          recv = rep_at[i].valid && (now < rep_at[i].ms || now - rep_at[i].ms <= ttl_ms);
          mutual = recv && rep_mask[i][self_id];
          flags[i] &= ~(F_DIRECT | F_ONEWAY | F_RELAY | F_COMMS);
          if (mutual) begin
            flags[i] |= F_DIRECT | F_COMMS;
            direct_at[i] = rep_at[i];
            if (!heard_at[i].valid || rep_at[i].ms > heard_at[i].ms) heard_at[i] = rep_at[i];
          end else if (recv) flags[i] |= F_ONEWAY;
        end
        if (closure_on) begin
          for (int i = 0; i < n; i++) begin
            if (i == self_id || flags[i][1]) continue;
            for (int b = 0; b < n; b++) begin
              if (b == self_id || b == i || !flags[b][1] || !rep_mask[b][i]) continue;
              flags[i] |= F_COMMS | F_RELAY | F_KNOWN;
              break;
            end
          end
        end
      end
      default: begin
        if (idx >= n) begin
          r.err = plgt_pkg::ERR_RANGE;
          r.known_age = plgt_pkg::AGE_UNKNOWN; r.pos_age = plgt_pkg::AGE_UNKNOWN;
          r.direct_age = plgt_pkg::AGE_UNKNOWN;
        end else begin
          r.pic = flags[idx][3];
          if (idx != self_id) begin
            r.known_age = stamp_age(heard_at[idx], now);
            r.direct_age = stamp_age(direct_at[idx], now);
          end
          r.pos_age = flags[idx][5] ? stamp_age(pos_at[idx], now) : plgt_pkg::AGE_UNKNOWN;
        end
      end
    endcase
    r.recv_mask[self_id] = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (flags[i][3]) r.comms_mask[i] = 1'b1;
      if (i == self_id) continue;
      if ((flags[i] & (F_DIRECT | F_ONEWAY)) != 8'd0) r.recv_mask[i] = 1'b1;
      if (!flags[i][3]) r.lost++;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [32:0] exp_v, logic [32:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    status_t e;
    if (rst) begin
      team_sz = 5'd1; self_id = '0; ttl_ms = 32'd1000; gossip_age_ms = 32'd1000;
      closure_on = 1'b1;
      wipe_table();
      expected_status.delete();
      fails = 0;
    end else begin
      // results first: a result leaving in the same cycle belongs to an older item
      if (m_tvalid && m_tready) begin
        if (expected_status.size() == 0) begin
          $error("result transaction with no expectation pending");
          fails++;
        end else begin
          e = expected_status.pop_front();
          check_field("error_code", 33'(e.err), 33'(m_tdata[1:0]));
          check_field("peer_in_comms", 33'(e.pic), 33'(m_tdata[2]));
          check_field("last_known_age_ms", e.known_age, m_tdata[35:3]);
          check_field("position_age_ms", e.pos_age, m_tdata[68:36]);
          check_field("last_direct_age_ms", e.direct_age, m_tdata[101:69]);
          check_field("in_comms_mask", 33'(e.comms_mask), 33'(m_tdata[117:102]));
          check_field("receiving_mask", 33'(e.recv_mask), 33'(m_tdata[133:118]));
          check_field("lost_count", 33'(e.lost), 33'(m_tdata[137:134]));
        end
      end
      if (s_tvalid && s_tready)
        expected_status.push_back(predict_status(plgt_pkg::cmd_t'(s_tuser), s_tdata));
      if (cfg_we) begin
        case (plgt_pkg::cfg_idx_t'(cfg_index))
          plgt_pkg::CFG_TEAM_SIZE:  begin team_sz = cfg_wdata[4:0]; wipe_table(); end
          plgt_pkg::CFG_SELF_INDEX: begin self_id = cfg_wdata[3:0]; wipe_table(); end
          plgt_pkg::CFG_DIRECT_TTL: ttl_ms = cfg_wdata;
          plgt_pkg::CFG_GOSSIP_AGE: gossip_age_ms = cfg_wdata;
          plgt_pkg::CFG_CLOSURE:    closure_on = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  final begin
    if (expected_status.size() != 0)
      $error("%0d expected results never arrived", expected_status.size());
  end

endmodule

>>> verif/peer_liveness_gossip_table_unit_tb.sv
// Stimulus and verdict for the peer liveness gossip table.
module peer_liveness_gossip_table_unit_tb;

  localparam int WATCHDOG = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [143:0] m_tdata;
  int           fails;

  int sent_cnt = 0, done_cnt = 0, quiet_cycles = 0;
  int hold_cnt = 0;
  bit long_hold_done = 0;
  logic [31:0] clock_ms = 0, pub_ms = 0;

  always #5 clk = ~clk;

  peer_liveness_gossip_table_unit dut (.*);

  peer_liveness_gossip_table_checker chk (.*);

  always @(posedge clk) begin
    if (s_tvalid && s_tready) sent_cnt <= sent_cnt + 1;
    if (m_tvalid && m_tready) done_cnt <= done_cnt + 1;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver backpressure, with one long hold-off once traffic is flowing
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) m_tready = 0;
    else if (hold_cnt > 0) begin
      m_tready = 0;
      hold_cnt--;
    end else if (!long_hold_done && sent_cnt >= 400) begin
      long_hold_done = 1;
      hold_cnt = 300;
      m_tready = 0;
    end else if (r < 10) begin
      hold_cnt = $urandom_range(0, 3);
      m_tready = 0;
    end else if (r < 12) begin
      hold_cnt = $urandom_range(15, 60);
      m_tready = 0;
    end else m_tready = 1;
  end

  function automatic logic [95:0] item_bits(logic [3:0] idx, logic [31:0] t, logic tv,
                                            logic [31:0] st, logic stv, logic [15:0] rm,
                                            logic fin, logic [2:0] md, logic hp);
    return {5'b0, hp, md, fin, rm, stv, st, tv, t, idx};
  endfunction

  // called at a falling edge; returns at a falling edge with tvalid low
  task automatic push_item(plgt_pkg::cmd_t c, logic [95:0] d);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    s_tvalid = 1; s_tuser = c; s_tdata = d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (done_cnt != sent_cnt) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(plgt_pkg::cfg_idx_t i, logic [31:0] v);
    cfg_we = 1; cfg_index = i; cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_config(logic [31:0] sz, logic [31:0] me, logic [31:0] ttl,
                            logic [31:0] gma, logic [31:0] cl);
    wait_drained();
    write_reg(plgt_pkg::CFG_TEAM_SIZE, sz);
    write_reg(plgt_pkg::CFG_SELF_INDEX, me);
    write_reg(plgt_pkg::CFG_DIRECT_TTL, ttl);
    write_reg(plgt_pkg::CFG_GOSSIP_AGE, gma);
    write_reg(plgt_pkg::CFG_CLOSURE, cl);
  endtask

  task automatic run_random(int count, int team);
    int r, k;
    logic [3:0] idx;
    logic [15:0] rm;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      clock_ms = (r == 0) ? $urandom : clock_ms + $urandom_range(0, 400);
      idx = 4'($urandom_range(0, (team > 15) ? 15 : team));
      if (r < 40) begin
        // header followed by a few gossip entries
        pub_ms = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms + $urandom_range(0, 2000);
        rm = 16'($urandom);
        if ($urandom_range(0, 3) != 0) rm = rm | 16'hffff;
        rm = $urandom_range(0, 1) ? rm : 16'($urandom);
        push_item(plgt_pkg::CMD_HEADER, item_bits(idx, clock_ms, 1'($urandom), pub_ms,
                  $urandom_range(0, 7) != 0, rm, 1'($urandom), 3'($urandom),
                  1'($urandom)));
        k = $urandom_range(0, 4);
        for (int e = 0; e < k; e++)
          push_item(plgt_pkg::CMD_ENTRY,
                    item_bits(4'($urandom_range(0, (team > 15) ? 15 : team)),
                    ($urandom_range(0, 7) == 0) ? pub_ms + $urandom_range(1, 50)
                                                : pub_ms - $urandom_range(0, 1500),
                    $urandom_range(0, 7) != 0, $urandom, 1'($urandom), 16'($urandom),
                    1'($urandom), 3'($urandom), 1'($urandom)));
        j += k;
      end else if (r < 60) begin
        push_item(plgt_pkg::CMD_TICK, item_bits(4'($urandom),
                  clock_ms + $urandom_range(0, 1200), 1'($urandom), $urandom,
                  1'($urandom), 16'($urandom), 1'($urandom), 3'($urandom), 1'($urandom)));
      end else if (r < 88) begin
        push_item(plgt_pkg::CMD_QUERY, item_bits(idx, clock_ms + $urandom_range(0, 500),
                  1'($urandom), $urandom, 1'($urandom), 16'($urandom), 1'($urandom),
                  3'($urandom), 1'($urandom)));
      end else begin
        push_item(plgt_pkg::cmd_t'($urandom_range(0, 3)), {$urandom, $urandom, $urandom});
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset settings: a team of one
    push_item(plgt_pkg::CMD_HEADER,
              item_bits(4'd0, 32'd10, 1'b1, 32'd5, 1'b1, 16'hffff, 1'b1, 3'd7, 1'b1));
    push_item(plgt_pkg::CMD_HEADER,
              item_bits(4'd1, 32'd10, 1'b1, 32'd5, 1'b1, 16'hffff, 1'b1, 3'd7, 1'b1));
    push_item(plgt_pkg::CMD_TICK,
              item_bits(4'd0, 32'd20, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b0));
    push_item(plgt_pkg::CMD_QUERY,
              item_bits(4'd0, 32'd30, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b0));

    // directed: team of four, self is 1
    set_config(4, 1, 100, 50, 1);
    push_item(plgt_pkg::CMD_ENTRY,  // no header yet
              item_bits(4'd2, 32'd0, 1'b1, 32'd0, 1'b0, 16'd0, 1'b1, 3'd2, 1'b1));
    push_item(plgt_pkg::CMD_HEADER,
              item_bits(4'd0, 32'd5, 1'b0, 32'd1000, 1'b1, 16'h0006, 1'b0, 3'd1, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,  // fits
              item_bits(4'd2, 32'd998, 1'b1, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,  // before zero
              item_bits(4'd3, 32'd900, 1'b1, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,  // after publish
              item_bits(4'd3, 32'd1001, 1'b1, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,  // latched sender
              item_bits(4'd0, 32'd999, 1'b1, 32'd0, 1'b0, 16'd0, 1'b1, 3'd7, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,  // self
              item_bits(4'd1, 32'd999, 1'b1, 32'd0, 1'b0, 16'd0, 1'b1, 3'd7, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,  // bad index
              item_bits(4'd5, 32'd999, 1'b1, 32'd0, 1'b0, 16'd0, 1'b1, 3'd7, 1'b1));
    push_item(plgt_pkg::CMD_ENTRY,
              item_bits(4'd3, 32'hffffffff, 1'b0, 32'd0, 1'b0, 16'd0, 1'b1, 3'd7, 1'b0));
    push_item(plgt_pkg::CMD_HEADER,
              item_bits(4'd1, 32'd7, 1'b0, 32'd0, 1'b0, 16'hffff, 1'b0, 3'd0, 1'b0));
    push_item(plgt_pkg::CMD_HEADER,
              item_bits(4'd9, 32'd7, 1'b0, 32'd0, 1'b0, 16'hffff, 1'b0, 3'd0, 1'b0));
    push_item(plgt_pkg::CMD_HEADER,
              item_bits(4'd2, 32'd8, 1'b0, 32'hffffffff, 1'b0, 16'h0001, 1'b1, 3'd7, 1'b0));
    push_item(plgt_pkg::CMD_ENTRY,  // no publish time
              item_bits(4'd3, 32'd8, 1'b1, 32'd0, 1'b0, 16'd0, 1'b0, 3'd3, 1'b1));
    push_item(plgt_pkg::CMD_TICK,   // reports newer
              item_bits(4'd0, 32'd3, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b0));
    for (int q = 0; q < 5; q++)
      push_item(plgt_pkg::CMD_QUERY,
                item_bits(q[3:0], 32'd50, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b0));
    push_item(plgt_pkg::CMD_TICK,
              item_bits(4'd0, 32'hffffffff, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b0));
    push_item(plgt_pkg::CMD_QUERY,
              item_bits(4'd0, 32'hffffffff, 1'b0, 32'd0, 1'b0, 16'd0, 1'b0, 3'd0, 1'b0));

    // random phases over several settings
    set_config(16, 15, 32'hffffffff, 32'hffffffff, 1); run_random(180, 16);
    set_config(16, 0, 0, 0, 0);                        run_random(150, 16);
    set_config(8, 3, 500, 300, 1);                     run_random(200, 8);
    set_config(5, 2, 1000, 1000, 0);                   run_random(150, 5);
    set_config(2, 0, 200, 700, 1);                     run_random(120, 2);
    set_config(3, 7, 100, 100, 1);                     run_random(30, 16);
    set_config(0, 0, 100, 100, 1);                     run_random(20, 16);
    set_config(31, 0, 100, 100, 1);                    run_random(20, 16);
    set_config(12, 11, 1500, 600, 1);                  run_random(150, 12);

    while (done_cnt != sent_cnt) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
